// ===== rtl/wshc_pkg.sv =====
package wshc_pkg;

  localparam int DIM_BITS = 16;
  localparam int BOUND    = (DIM_BITS < 16) ? (2 ** DIM_BITS) - 1 : 65535;

  localparam int QBITS  = 17;
  localparam int DIVW   = 49;
  localparam int DENW   = 33;
  localparam int NST    = 3 + 2 * (QBITS + 1) + 1;

  localparam logic [2:0] REG_MIN_SIZE   = 3'd0;
  localparam logic [2:0] REG_MAX_SIZE   = 3'd1;
  localparam logic [2:0] REG_BASE_SIZE  = 3'd2;
  localparam logic [2:0] REG_SIZE_INC   = 3'd3;
  localparam logic [2:0] REG_MIN_ASPECT = 3'd4;
  localparam logic [2:0] REG_MAX_ASPECT = 3'd5;

endpackage

// ===== rtl/window_size_hint_constrainer.sv =====
// Size-hint constrainer: each request (a width and height transfer) is clamped to the
// min/max sizes, projected onto the violated aspect line with exact truncating
// integer arithmetic, and quantized to base plus whole increments. The pipeline
// takes one transfer per cycle while the output is not stalled; its depth is set
// by two bit-serial divider pipelines of 18 stages each (aspect projection and
// increment quantization). A stalled output holds the whole pipeline. The user
// must write configuration only while no transfer is in flight; no logic enforces it.
module window_size_hint_constrainer
  import wshc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [16:0] in_req_width,
  input  logic signed [16:0] in_req_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_fit_width,
  output logic [15:0]        out_fit_height,
  output logic signed [16:0] out_width_steps,
  output logic signed [16:0] out_height_steps
);

  logic [31:0] min_size_r, max_size_r, base_size_r, size_inc_r, min_asp_r, max_asp_r;
  logic [NST-1:0] vld_r;
  logic adv;

  logic [15:0] minw, minh, maxw, maxh, bw, bh, incw, inch, mnx, mny, mxx, mxy;

  assign minw = min_size_r[15:0];
  assign minh = min_size_r[31:16];
  assign maxw = max_size_r[15:0];
  assign maxh = max_size_r[31:16];
  assign bw   = base_size_r[15:0];
  assign bh   = base_size_r[31:16];
  assign incw = (size_inc_r[15:0] == 16'd0) ? 16'd1 : size_inc_r[15:0];
  assign inch = (size_inc_r[31:16] == 16'd0) ? 16'd1 : size_inc_r[31:16];
  assign mnx  = min_asp_r[15:0];
  assign mny  = min_asp_r[31:16];
  assign mxx  = max_asp_r[15:0];
  assign mxy  = max_asp_r[31:16];

  assign adv       = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r  <= 32'h0001_0001;
      max_size_r  <= 32'h0;
      base_size_r <= 32'h0001_0001;
      size_inc_r  <= 32'h0001_0001;
      min_asp_r   <= 32'h0;
      max_asp_r   <= 32'h0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_SIZE:   min_size_r  <= cfg_data;
        REG_MAX_SIZE:   max_size_r  <= cfg_data;
        REG_BASE_SIZE:  base_size_r <= cfg_data;
        REG_SIZE_INC:   size_inc_r  <= cfg_data;
        REG_MIN_ASPECT: min_asp_r   <= cfg_data;
        REG_MAX_ASPECT: max_asp_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Clamp to min and max.
  logic [15:0] wa_nxt, ha_nxt, wa_r, ha_r;
  logic [15:0] wlo, hlo;

  always_comb begin
    wlo = (in_req_width < $signed({1'b0, minw})) ? minw : in_req_width[15:0];
    hlo = (in_req_height < $signed({1'b0, minh})) ? minh : in_req_height[15:0];
    wa_nxt = (maxw != 16'd0 && wlo > maxw) ? maxw : wlo;
    ha_nxt = (maxh != 16'd0 && hlo > maxh) ? maxh : hlo;
  end

  // Offsets from base and aspect cross products.
  logic signed [16:0] pd, qd;
  logic [15:0] wb_r, hb_r, pb_r, qb_r;
  logic        enb_nxt, enb_r;
  logic [31:0] m0_r, m1_r, m2_r, m3_r;

  always_comb begin
    pd = $signed({1'b0, wa_r}) - $signed({1'b0, bw});
    qd = $signed({1'b0, ha_r}) - $signed({1'b0, bh});
    enb_nxt = (mny != 16'd0) && (mxy != 16'd0) && (mnx != 16'd0) && (mxx != 16'd0) &&
              (pd > 17'sd0) && (qd > 17'sd0);
  end

  // Select the violated line, form s and the squared norm.
  logic        below, above;
  logic [15:0] asel, bsel;
  logic [15:0] wc_r, hc_r;
  logic        hitc_nxt, hitc_r;
  logic [32:0] sc_nxt, dc_nxt, sc_r, dc_r;
  logic [15:0] ac_r, bc_r;

  always_comb begin
    below    = m0_r < m1_r;
    above    = m2_r > m3_r;
    hitc_nxt = enb_r && (below || above);
    asel     = below ? mnx : mxx;
    bsel     = below ? mny : mxy;
    sc_nxt   = {1'b0, 32'(pb_r) * 32'(asel)} + {1'b0, 32'(qb_r) * 32'(bsel)};
    dc_nxt   = {1'b0, 32'(asel) * 32'(asel)} + {1'b0, 32'(bsel) * 32'(bsel)};
  end

  // Projection dividers: one quotient bit per stage.
  logic [DIVW-1:0]  xr_r [0:QBITS];
  logic [DIVW-1:0]  yr_r [0:QBITS];
  logic [DENW-1:0]  dd_r [0:QBITS];
  logic [QBITS-1:0] qx_r [0:QBITS];
  logic [QBITS-1:0] qy_r [0:QBITS];
  logic [15:0]      wd_r [0:QBITS];
  logic [15:0]      hd_r [0:QBITS];
  logic             hd_hit_r [0:QBITS];

  logic [DIVW-1:0]  xr_nxt [0:QBITS-1];
  logic [DIVW-1:0]  yr_nxt [0:QBITS-1];
  logic [QBITS-1:0] qx_nxt [0:QBITS-1];
  logic [QBITS-1:0] qy_nxt [0:QBITS-1];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      logic [DIVW-1:0] dsh;
      dsh = DIVW'(dd_r[k]) << (QBITS - 1 - k);
      if (xr_r[k] >= dsh) begin
        xr_nxt[k] = xr_r[k] - dsh;
        qx_nxt[k] = {qx_r[k][QBITS-2:0], 1'b1};
      end else begin
        xr_nxt[k] = xr_r[k];
        qx_nxt[k] = {qx_r[k][QBITS-2:0], 1'b0};
      end
      if (yr_r[k] >= dsh) begin
        yr_nxt[k] = yr_r[k] - dsh;
        qy_nxt[k] = {qy_r[k][QBITS-2:0], 1'b1};
      end else begin
        yr_nxt[k] = yr_r[k];
        qy_nxt[k] = {qy_r[k][QBITS-2:0], 1'b0};
      end
    end
  end

  // Offsets after repair, split into sign and magnitude.
  logic [17:0]        wn, hn;
  logic signed [18:0] dw, dh;
  logic [16:0]        magw_nxt, magh_nxt;

  always_comb begin
    wn = hd_hit_r[QBITS] ? (18'(qx_r[QBITS]) + 18'(bw)) : 18'(wd_r[QBITS]);
    hn = hd_hit_r[QBITS] ? (18'(qy_r[QBITS]) + 18'(bh)) : 18'(hd_r[QBITS]);
    dw = $signed({1'b0, wn}) - $signed({3'b0, bw});
    dh = $signed({1'b0, hn}) - $signed({3'b0, bh});
    magw_nxt = dw[18] ? 17'(-dw) : dw[16:0];
    magh_nxt = dh[18] ? 17'(-dh) : dh[16:0];
  end

  // Increment dividers.
  logic [QBITS-1:0] rw_r [0:QBITS];
  logic [QBITS-1:0] rh_r [0:QBITS];
  logic [QBITS-1:0] sw_r [0:QBITS];
  logic [QBITS-1:0] sh_r [0:QBITS];
  logic             nw_r [0:QBITS];
  logic             nh_r [0:QBITS];

  logic [QBITS-1:0] rw_nxt [0:QBITS-1];
  logic [QBITS-1:0] rh_nxt [0:QBITS-1];
  logic [QBITS-1:0] sw_nxt [0:QBITS-1];
  logic [QBITS-1:0] sh_nxt [0:QBITS-1];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      logic [32:0] iwsh, ihsh;
      iwsh = 33'(incw) << (QBITS - 1 - k);
      ihsh = 33'(inch) << (QBITS - 1 - k);
      if (33'(rw_r[k]) >= iwsh) begin
        rw_nxt[k] = rw_r[k] - iwsh[QBITS-1:0];
        sw_nxt[k] = {sw_r[k][QBITS-2:0], 1'b1};
      end else begin
        rw_nxt[k] = rw_r[k];
        sw_nxt[k] = {sw_r[k][QBITS-2:0], 1'b0};
      end
      if (33'(rh_r[k]) >= ihsh) begin
        rh_nxt[k] = rh_r[k] - ihsh[QBITS-1:0];
        sh_nxt[k] = {sh_r[k][QBITS-2:0], 1'b1};
      end else begin
        rh_nxt[k] = rh_r[k];
        sh_nxt[k] = {sh_r[k][QBITS-2:0], 1'b0};
      end
    end
  end

  // Rebuild sizes and saturate.
  logic [17:0]        pw, ph;
  logic signed [19:0] fw, fh;
  logic [16:0]        cw, ch;
  logic [15:0]        fw_nxt, fh_nxt;
  logic signed [16:0] sw_o_nxt, sh_o_nxt;

  always_comb begin
    pw = 18'(sw_r[QBITS]) * 18'(incw);
    ph = 18'(sh_r[QBITS]) * 18'(inch);
    fw = nw_r[QBITS] ? ($signed({4'b0, bw}) - $signed({2'b0, pw}))
                     : ($signed({4'b0, bw}) + $signed({2'b0, pw}));
    fh = nh_r[QBITS] ? ($signed({4'b0, bh}) - $signed({2'b0, ph}))
                     : ($signed({4'b0, bh}) + $signed({2'b0, ph}));
    if (fw < 20'sd0)
      fw_nxt = 16'd0;
    else if (fw > 20'(BOUND))
      fw_nxt = 16'(BOUND);
    else
      fw_nxt = fw[15:0];
    if (fh < 20'sd0)
      fh_nxt = 16'd0;
    else if (fh > 20'(BOUND))
      fh_nxt = 16'(BOUND);
    else
      fh_nxt = fh[15:0];
    cw = (sw_r[QBITS] > 17'(BOUND)) ? 17'(BOUND) : sw_r[QBITS];
    ch = (sh_r[QBITS] > 17'(BOUND)) ? 17'(BOUND) : sh_r[QBITS];
    sw_o_nxt = nw_r[QBITS] ? -$signed(cw) : $signed(cw);
    sh_o_nxt = nh_r[QBITS] ? -$signed(ch) : $signed(ch);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wa_r <= wa_nxt;
      ha_r <= ha_nxt;

      wb_r  <= wa_r;
      hb_r  <= ha_r;
      pb_r  <= pd[15:0];
      qb_r  <= qd[15:0];
      enb_r <= enb_nxt;
      m0_r  <= 32'(pd[15:0]) * 32'(mny);
      m1_r  <= 32'(mnx) * 32'(qd[15:0]);
      m2_r  <= 32'(pd[15:0]) * 32'(mxy);
      m3_r  <= 32'(mxx) * 32'(qd[15:0]);

      wc_r   <= wb_r;
      hc_r   <= hb_r;
      hitc_r <= hitc_nxt;
      sc_r   <= sc_nxt;
      dc_r   <= dc_nxt;
      ac_r   <= asel;
      bc_r   <= bsel;

      xr_r[0]     <= DIVW'(sc_r) * DIVW'(ac_r);
      yr_r[0]     <= DIVW'(sc_r) * DIVW'(bc_r);
      dd_r[0]     <= dc_r;
      qx_r[0]     <= '0;
      qy_r[0]     <= '0;
      wd_r[0]     <= wc_r;
      hd_r[0]     <= hc_r;
      hd_hit_r[0] <= hitc_r;
      for (int k = 0; k < QBITS; k++) begin
        xr_r[k+1]     <= xr_nxt[k];
        yr_r[k+1]     <= yr_nxt[k];
        qx_r[k+1]     <= qx_nxt[k];
        qy_r[k+1]     <= qy_nxt[k];
        dd_r[k+1]     <= dd_r[k];
        wd_r[k+1]     <= wd_r[k];
        hd_r[k+1]     <= hd_r[k];
        hd_hit_r[k+1] <= hd_hit_r[k];
      end

      rw_r[0] <= magw_nxt;
      rh_r[0] <= magh_nxt;
      sw_r[0] <= '0;
      sh_r[0] <= '0;
      nw_r[0] <= dw[18];
      nh_r[0] <= dh[18];
      for (int k = 0; k < QBITS; k++) begin
        rw_r[k+1] <= rw_nxt[k];
        rh_r[k+1] <= rh_nxt[k];
        sw_r[k+1] <= sw_nxt[k];
        sh_r[k+1] <= sh_nxt[k];
        nw_r[k+1] <= nw_r[k];
        nh_r[k+1] <= nh_r[k];
      end

      out_fit_width    <= fw_nxt;
      out_fit_height   <= fh_nxt;
      out_width_steps  <= sw_o_nxt;
      out_height_steps <= sh_o_nxt;
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import wshc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 40;
  localparam int N_RANDOM  = 1080;
  localparam int WATCHDOG  = 5000;

  typedef struct packed {
    logic [15:0]        fit_w;
    logic [15:0]        fit_h;
    logic signed [16:0] steps_w;
    logic signed [16:0] steps_h;
  } fit_t;

  typedef struct {
    logic signed [16:0] w;
    logic signed [16:0] h;
    logic               has_fit;
    fit_t               fit;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [16:0] in_req_width;
  logic signed [16:0] in_req_height;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_fit_width;
  logic [15:0]        out_fit_height;
  logic signed [16:0] out_width_steps;
  logic signed [16:0] out_height_steps;

  logic [31:0] hint [0:5];
  fit_t        pending_fits[$];
  int          mismatches;
  int          table_errs;
  int          fits_seen;
  int          idle_cycles;
  int          stall_left;
  bit          calm;
  bit          timed_out;

  window_size_hint_constrainer u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint lo16(logic [31:0] r);
    return longint'(r[15:0]);
  endfunction

  function automatic longint hi16(logic [31:0] r);
    return longint'(r[31:16]);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic fit_t constrain_size(logic signed [16:0] rw, logic signed [16:0] rh);
    longint w, h, p, q, a, b, s, d, iw, ih, incw, inch, bw, bh;
    longint mnx, mny, mxx, mxy;
    bit     hit;
    fit_t   f;
    w = rw;
    h = rh;
    bw = lo16(hint[REG_BASE_SIZE]);
    bh = hi16(hint[REG_BASE_SIZE]);
    mnx = lo16(hint[REG_MIN_ASPECT]);
    mny = hi16(hint[REG_MIN_ASPECT]);
    mxx = lo16(hint[REG_MAX_ASPECT]);
    mxy = hi16(hint[REG_MAX_ASPECT]);
    hit = 1'b0;
    if (w < lo16(hint[REG_MIN_SIZE])) w = lo16(hint[REG_MIN_SIZE]);
    if (h < hi16(hint[REG_MIN_SIZE])) h = hi16(hint[REG_MIN_SIZE]);
    if (lo16(hint[REG_MAX_SIZE]) > 0 && w > lo16(hint[REG_MAX_SIZE]))
      w = lo16(hint[REG_MAX_SIZE]);
    if (hi16(hint[REG_MAX_SIZE]) > 0 && h > hi16(hint[REG_MAX_SIZE]))
      h = hi16(hint[REG_MAX_SIZE]);
    p = w - bw;
    q = h - bh;
    if (mny > 0 && mxy > 0 && mnx > 0 && mxx > 0 && p > 0 && q > 0) begin
      if (p * mny < mnx * q) begin
        a = mnx;
        b = mny;
        hit = 1'b1;
      end else if (p * mxy > mxx * q) begin
        a = mxx;
        b = mxy;
        hit = 1'b1;
      end
      if (hit) begin
        s = p * a + q * b;
        d = a * a + b * b;
        w = (s * a) / d + bw;
        h = (s * b) / d + bh;
      end
    end
    incw = lo16(hint[REG_SIZE_INC]);
    inch = hi16(hint[REG_SIZE_INC]);
    if (incw == 0) incw = 1;
    if (inch == 0) inch = 1;
    iw = (w - bw) / incw;
    ih = (h - bh) / inch;
    f.fit_w = 16'(clip(iw * incw + bw, 0, BOUND));
    f.fit_h = 16'(clip(ih * inch + bh, 0, BOUND));
    f.steps_w = 17'(clip(iw, -BOUND, BOUND));
    f.steps_h = 17'(clip(ih, -BOUND, BOUND));
    return f;
  endfunction

  task automatic write_hint(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    hint[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_request(logic signed [16:0] w, logic signed [16:0] h, bit has_fit,
                              fit_t fit);
    fit_t want;
    int   gap;
    want = constrain_size(w, h);
    if (has_fit && want != fit) begin
      table_errs++;
      $display("table entry w=%0d h=%0d: table %p, predictor %p", w, h, fit, want);
    end
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_width <= w;
    in_req_height <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_fits.insert(pending_fits.size(), want);
  endtask

  function automatic logic [31:0] rand_pair(int mode);
    logic [15:0] lo, hi;
    case (mode)
      0: begin
        lo = 16'($urandom_range(0, 40));
        hi = 16'($urandom_range(0, 40));
      end
      1: begin
        lo = 16'($urandom_range(0, 2000));
        hi = 16'($urandom_range(0, 2000));
      end
      default: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
    endcase
    return {hi, lo};
  endfunction

  always @(posedge clk) begin
    fit_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_fit_width, out_fit_height, out_width_steps, out_height_steps};
      fits_seen++;
      if (pending_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", got);
      end else if (pending_fits[0] !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("transfer %0d: expected %p, got %p", fits_seen, pending_fits[0], got);
        void'(pending_fits.pop_front());
      end else begin
        void'(pending_fits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || pending_fits.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("window_size_hint_constrainer: mismatch");
      $finish;
    end
  end

  row_t rows[$];

  function automatic void add_row(logic signed [16:0] w, logic signed [16:0] h,
                                  logic has_fit, fit_t fit);
    rows.insert(rows.size(), row_t'{w, h, has_fit, fit});
  endfunction

  initial begin
    fit_t        none;
    logic [31:0] v;
    int          k;
    none = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_width = '0;
    in_req_height = '0;
    calm = 1'b0;
    hint[0] = 32'h0001_0001;
    hint[1] = 32'h0;
    hint[2] = 32'h0001_0001;
    hint[3] = 32'h0001_0001;
    hint[4] = 32'h0;
    hint[5] = 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: minimum and base are one, step is one, no maximum, no aspect.
    add_row(17'sd0, 17'sd0, 1'b1, '{16'd1, 16'd1, 17'sd0, 17'sd0});
    add_row(-17'sd65536, -17'sd1, 1'b1, '{16'd1, 16'd1, 17'sd0, 17'sd0});
    add_row(17'sd65535, 17'sd65535, 1'b1,
            '{16'd65535, 16'd65535, 17'sd65534, 17'sd65534});
    add_row(17'sd100, 17'sd7, 1'b1, '{16'd100, 16'd7, 17'sd99, 17'sd6});
    add_row(17'sd1, 17'sd65535, 1'b1, '{16'd1, 16'd65535, 17'sd0, 17'sd65534});
    add_row(17'sh0AAAA, 17'sh15555, 1'b0, none);
    foreach (rows[i]) send_request(rows[i].w, rows[i].h, rows[i].has_fit, rows[i].fit);
    drain();

    // Minimum zero, base above the request: negative step counts toward base.
    write_hint(REG_MIN_SIZE, 32'h0);
    write_hint(REG_MAX_SIZE, 32'h0050_0060);
    write_hint(REG_BASE_SIZE, 32'h0020_0020);
    write_hint(REG_SIZE_INC, 32'h0000_0007);
    write_hint(REG_MIN_ASPECT, 32'h0003_0001);
    write_hint(REG_MAX_ASPECT, 32'h0001_0003);
    rows.delete();
    add_row(17'sd0, 17'sd0, 1'b1, '{16'd4, 16'd0, -17'sd4, -17'sd32});
    add_row(17'sd90, 17'sd31, 1'b0, none);
    add_row(17'sd40, 17'sd79, 1'b0, none);
    add_row(17'sd60, 17'sd60, 1'b0, none);
    add_row(17'sd200, 17'sd200, 1'b0, none);
    add_row(17'sd33, 17'sd79, 1'b0, none);
    add_row(17'sd95, 17'sd33, 1'b0, none);
    foreach (rows[i]) send_request(rows[i].w, rows[i].h, rows[i].has_fit, rows[i].fit);
    drain();

    // Extreme hints: sizes and increments at full scale, base zero, extreme aspects.
    write_hint(REG_MIN_SIZE, 32'hFFFF_FFFF);
    write_hint(REG_MAX_SIZE, 32'hFFFF_FFFF);
    write_hint(REG_BASE_SIZE, 32'h0);
    write_hint(REG_SIZE_INC, 32'hFFFF_FFFF);
    write_hint(REG_MIN_ASPECT, 32'hFFFF_0001);
    write_hint(REG_MAX_ASPECT, 32'h0001_FFFF);
    send_request(-17'sd65536, 17'sd65535, 1'b1, '{16'd65535, 16'd65535, 17'sd1, 17'sd1});
    send_request(17'sd12, 17'sd3, 1'b0, none);
    drain();

    // Random phases: fresh hints, then a batch of requests.
    for (int phase = 0; phase < 12; phase++) begin
      for (int r = 0; r < 6; r++) begin
        k = $urandom_range(0, 4);
        v = rand_pair(k < 2 ? 0 : k < 4 ? 1 : 2);
        if (r == REG_MAX_SIZE && $urandom_range(0, 2) == 0) v = 32'h0;
        if ((r == REG_MIN_ASPECT || r == REG_MAX_ASPECT) && $urandom_range(0, 5) == 0)
          v = 32'h0;
        write_hint(3'(r), v);
      end
      calm = (phase == 11);
      for (int n = 0; n < N_RANDOM / 12; n++) begin
        k = $urandom_range(0, 9);
        if (k < 6)
          send_request(17'($urandom_range(0, 3000)) - 17'sd200,
                       17'($urandom_range(0, 3000)) - 17'sd200, 1'b0, none);
        else
          send_request(17'($urandom), 17'($urandom), 1'b0, none);
        if (n == 40 && phase == 3) begin
          in_valid <= 1'b0;
          while (pending_fits.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Checked %0d transfers over reset, directed and twelve random hint sets,",
             fits_seen);
    $display("covering clamps, both aspect repairs, negative steps and saturation.");
    if (mismatches == 0 && table_errs == 0 && pending_fits.size() == 0)
      $display("window_size_hint_constrainer: match");
    else
      $display("window_size_hint_constrainer: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/wshc_pkg.sv
rtl/window_size_hint_constrainer.sv
sim/tb.sv
